[rtl/core/cht_pkg.sv]
// ----------------------------------------------------------------------------
// cht_pkg: shared constants and types for the chained hash table core
// Command and status codes and the hash-unit request/response structs.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int KEY_W     = 64;
  localparam int LEN_W     = 4;
  localparam int VAL_W     = 32;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;
  localparam int CNT_W     = 9;
  localparam int BCNT_W    = 7;
  localparam int HASH_W    = 64;
  localparam int MIN_BKT   = 5;

  localparam logic [CMD_W-1:0] CMD_GET    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUT    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS    = 2'd1;
  localparam logic [STAT_W-1:0] ST_DUP     = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic              start;
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  len;
    logic [BCNT_W-1:0] divisor;
  } hash_req_t;

  typedef struct packed {
    logic              done;
    logic [BCNT_W-1:0] bucket;
  } hash_rsp_t;

endpackage

[rtl/core/cht_hash.sv]
// ----------------------------------------------------------------------------
// cht_hash: iterative key hash and remainder unit
// One byte of hash per cycle, then one remainder bit per cycle (restoring).
// ----------------------------------------------------------------------------
module cht_hash (
  input  logic               clk,
  input  logic               rst_n,
  input  cht_pkg::hash_req_t req,
  output cht_pkg::hash_rsp_t rsp
);

  typedef enum logic [1:0] {S_IDLE, S_HASH, S_MOD} state_t;

  state_t                        state_r;
  logic [cht_pkg::KEY_W-1:0]     key_r;
  logic [cht_pkg::LEN_W-1:0]     idx_r;
  logic [cht_pkg::HASH_W-1:0]    hash_r;
  logic [6:0]                    bit_r;
  logic [cht_pkg::BCNT_W:0]      rem_r;
  logic [cht_pkg::BCNT_W-1:0]    div_r;
  logic                          done_r;

  logic [7:0]                    byte_sel;
  logic [cht_pkg::BCNT_W+1:0]    rem_sh;
  logic [cht_pkg::BCNT_W+1:0]    rem_sub;

  assign byte_sel = key_r[{idx_r[2:0] - 3'd1, 3'b000} +: 8];
  assign rem_sh   = {rem_r, hash_r[bit_r[5:0]]};
  assign rem_sub  = rem_sh - {2'b00, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == S_MOD) && (bit_r == 7'd0);
      case (state_r)
        S_IDLE: begin
          if (req.start) begin
            key_r   <= req.key;
            idx_r   <= req.len;
            hash_r  <= {{(cht_pkg::HASH_W-cht_pkg::LEN_W){1'b0}}, req.len};
            div_r   <= req.divisor;
            state_r <= S_HASH;
          end
        end
        S_HASH: begin
          if (idx_r == '0) begin
            bit_r   <= 7'd63;
            rem_r   <= '0;
            state_r <= S_MOD;
          end else begin
            hash_r <= (hash_r << 4) + {56'd0, byte_sel};
            idx_r  <= idx_r - 4'd1;
          end
        end
        S_MOD: begin
          if (rem_sub[cht_pkg::BCNT_W+1]) begin
            rem_r <= rem_sh[cht_pkg::BCNT_W:0];
          end else begin
            rem_r <= rem_sub[cht_pkg::BCNT_W:0];
          end
          bit_r <= bit_r - 7'd1;
          if (bit_r == 7'd0) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.done   = done_r;
  assign rsp.bucket = rem_r[cht_pkg::BCNT_W-1:0];

endmodule

[rtl/core/chained_hash_table_core.sv]
// ----------------------------------------------------------------------------
// chained_hash_table_core: key/value store, fixed ways per bucket
// Hash, bucket select by remainder, way-by-way slot scan, then update.
// ----------------------------------------------------------------------------
//  channel | direction | handshake
//  in_     | input     | in_valid / in_stall
//  out_    | output    | out_valid / out_stall
//  cfg_    | APB       | psel / penable / pwrite, pready tied high
//
// An item is taken, a registered start goes to the hash unit, which hashes
// the len key bytes and takes the remainder by the bucket count; the core
// takes the bucket, reads and compares the ways of that bucket in turn and
// ends with one update step; the next item is taken once it is idle again.
// Reset clears all slot valid bits at once; no clearing pass. in_stall is high
// while an item is in work; a result held by out_stall holds the next update.
module chained_hash_table_core #(
  parameter int KEY_BYTES = 8,
  parameter int BUCKETS   = 64,
  parameter int WAYS      = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cht_pkg::CMD_W-1:0]     in_command,
  input  logic [cht_pkg::KEY_W-1:0]     in_key_bytes,
  input  logic [cht_pkg::LEN_W-1:0]     in_key_length,
  input  logic [cht_pkg::VAL_W-1:0]     in_value_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cht_pkg::STAT_W-1:0]    out_status,
  output logic [cht_pkg::VAL_W-1:0]     out_value_out,
  output logic [cht_pkg::CNT_W-1:0]     out_entry_count,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic                          cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);

  localparam int SLOTS  = BUCKETS * WAYS;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WCNT_W = $clog2(WAYS + 1);

  typedef enum logic [2:0] {S_IDLE, S_HASH, S_READ, S_CMP, S_ACT} state_t;

  state_t                           state_r;
  logic [cht_pkg::BCNT_W-1:0]       bcnt_r;
  logic [cht_pkg::CMD_W-1:0]        cmd_r;
  logic [cht_pkg::KEY_W-1:0]        key_r;
  logic [cht_pkg::LEN_W-1:0]        len_r;
  logic [cht_pkg::VAL_W-1:0]        val_r;
  logic [SLOT_W-1:0]                base_r;
  logic [WCNT_W-1:0]                way_r;
  logic                             hit_r;
  logic [WAY_W-1:0]                 hit_way_r;
  logic [cht_pkg::VAL_W-1:0]        hval_r;
  logic                             free_r;
  logic [WAY_W-1:0]                 free_way_r;
  logic [cht_pkg::CNT_W-1:0]        live_r;
  logic                             hstart_r;

  logic [SLOTS-1:0]                 valid_r;
  logic [cht_pkg::KEY_W-1:0]        mkey   [SLOTS];
  logic [cht_pkg::LEN_W-1:0]        mlen   [SLOTS];
  logic [cht_pkg::VAL_W-1:0]        mval   [SLOTS];
  logic [cht_pkg::KEY_W-1:0]        rkey_r;
  logic [cht_pkg::LEN_W-1:0]        rlen_r;
  logic [cht_pkg::VAL_W-1:0]        rval_r;
  logic                             rvld_r;

  logic                             out_valid_r;
  logic [cht_pkg::STAT_W-1:0]       status_r;
  logic [cht_pkg::VAL_W-1:0]        vout_r;

  cht_pkg::hash_req_t               hreq;
  cht_pkg::hash_rsp_t               hrsp;

  logic [cht_pkg::LEN_W-1:0]        len_sat;
  logic [cht_pkg::KEY_W-1:0]        key_msk;
  logic [cht_pkg::BCNT_W-1:0]       bcnt_eff;
  logic [SLOT_W-1:0]                rd_addr;
  logic [SLOT_W-1:0]                hit_addr;
  logic [SLOT_W-1:0]                free_addr;
  logic                             in_acc;
  logic                             cfg_wr;
  logic                             out_free;
  logic                             act_go;

  assign len_sat = (in_key_length > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : in_key_length;
  always_comb begin
    key_msk = '0;
    for (int b = 0; b < KEY_BYTES; b++) begin
      if (4'(b) < len_sat) key_msk[b*8 +: 8] = in_key_bytes[b*8 +: 8];
    end
  end

  always_comb begin
    if (bcnt_r < 7'(cht_pkg::MIN_BKT)) bcnt_eff = 7'(cht_pkg::MIN_BKT);
    else if ({25'd0, bcnt_r} > 32'(BUCKETS)) bcnt_eff = 7'(BUCKETS);
    else bcnt_eff = bcnt_r;
  end

  assign hreq.start   = hstart_r;
  assign hreq.key     = key_r;
  assign hreq.len     = len_r;
  assign hreq.divisor = bcnt_eff;

  cht_hash u_hash (.clk(clk), .rst_n(rst_n), .req(hreq), .rsp(hrsp));

  assign in_stall   = (state_r != S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign act_go     = (state_r == S_ACT) && out_free;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr;
  assign cfg_prdata = cfg_paddr ? 32'd0 : {25'd0, bcnt_r};

  assign rd_addr   = base_r + SLOT_W'(way_r);
  assign hit_addr  = base_r + SLOT_W'(hit_way_r);
  assign free_addr = base_r + SLOT_W'(free_way_r);

  always_ff @(posedge clk) begin
    rkey_r <= mkey[rd_addr];
    rlen_r <= mlen[rd_addr];
    rval_r <= mval[rd_addr];
    if (act_go && cmd_r == cht_pkg::CMD_PUT && !hit_r && free_r) begin
      mkey[free_addr] <= key_r;
      mlen[free_addr] <= len_r;
      mval[free_addr] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bcnt_r      <= 7'(cht_pkg::MIN_BKT);
      valid_r     <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
      hstart_r    <= 1'b0;
    end else begin
      hstart_r    <= in_acc;
      out_valid_r <= act_go || (out_valid_r && out_stall);
      if (cfg_wr) bcnt_r <= cfg_pwdata[cht_pkg::BCNT_W-1:0];
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r    <= in_command;
            key_r    <= key_msk;
            len_r    <= len_sat;
            val_r    <= in_value_in;
            state_r  <= S_HASH;
          end
        end
        S_HASH: begin
          if (hrsp.done) begin
            base_r  <= SLOT_W'(hrsp.bucket) * SLOT_W'(WAYS);
            way_r   <= '0;
            hit_r   <= 1'b0;
            free_r  <= 1'b0;
            state_r <= S_READ;
          end
        end
        S_READ: begin
          rvld_r  <= valid_r[rd_addr];
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (rvld_r) begin
            if (!hit_r && rlen_r == len_r && rkey_r == key_r) begin
              hit_r     <= 1'b1;
              hit_way_r <= WAY_W'(way_r);
              hval_r    <= rval_r;
            end
          end else if (!free_r) begin
            free_r     <= 1'b1;
            free_way_r <= WAY_W'(way_r);
          end
          if (way_r == WCNT_W'(WAYS - 1)) begin
            state_r <= S_ACT;
          end else begin
            way_r   <= way_r + 1'b1;
            state_r <= S_READ;
          end
        end
        S_ACT: begin
          if (out_free) begin
            state_r <= S_IDLE;
            case (cmd_r)
              cht_pkg::CMD_GET: begin
                status_r <= hit_r ? cht_pkg::ST_OK : cht_pkg::ST_MISS;
                vout_r   <= hit_r ? hval_r : '0;
              end
              cht_pkg::CMD_PUT: begin
                vout_r <= '0;
                if (hit_r) status_r <= cht_pkg::ST_DUP;
                else if (!free_r) status_r <= cht_pkg::ST_FULL;
                else begin
                  status_r           <= cht_pkg::ST_OK;
                  valid_r[free_addr] <= 1'b1;
                  live_r             <= live_r + 1'b1;
                end
              end
              cht_pkg::CMD_REMOVE: begin
                vout_r <= '0;
                if (hit_r) begin
                  status_r          <= cht_pkg::ST_OK;
                  valid_r[hit_addr] <= 1'b0;
                  live_r            <= live_r - 1'b1;
                end else begin
                  status_r <= cht_pkg::ST_MISS;
                end
              end
              default: begin
                status_r <= cht_pkg::ST_OK;
                vout_r   <= '0;
              end
            endcase
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_value_out   = vout_r;
  assign out_entry_count = live_r;

endmodule
